### rtl/ifs_pkg.sv
// Package for the image format sniffer: result codes, signature tables and brand check.
package ifs_pkg;

    // Result codes carried on format_code
    typedef enum logic [2:0] {
        FMT_UNKNOWN = 3'd0,
        FMT_JPEG    = 3'd1,
        FMT_PNG     = 3'd2,
        FMT_GIF     = 3'd3,
        FMT_BMP     = 3'd4,
        FMT_TIFF    = 3'd5,
        FMT_ICO     = 3'd6,
        FMT_HEIF    = 3'd7
    } fmt_t;

    // Coarse viewer classes carried on viewer_class
    typedef enum logic [2:0] {
        CLS_UNSUPPORTED = 3'd0,
        CLS_JPEG        = 3'd1,
        CLS_PNG         = 3'd2,
        CLS_HEIF        = 3'd3,
        CLS_OTHER       = 3'd4
    } cls_t;

    // Fixed prefix signatures, one flag each
    localparam int SIG_COUNT      = 10;
    localparam int SIG_JPEG       = 0;
    localparam int SIG_PNG        = 1;
    localparam int SIG_GIF87      = 2;
    localparam int SIG_GIF89      = 3;
    localparam int SIG_BMP        = 4;
    localparam int SIG_TIFF_II_42 = 5;
    localparam int SIG_TIFF_MM_42 = 6;
    localparam int SIG_TIFF_II_43 = 7;
    localparam int SIG_TIFF_MM_43 = 8;
    localparam int SIG_ICO        = 9;

    typedef logic [SIG_COUNT-1:0] sig_flags_t;

    localparam logic [7:0] SIG_BYTES [SIG_COUNT][8] = '{
        '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00},
        '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4D, 8'h00, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] SIG_LEN [SIG_COUNT] = '{
        4'd3, 4'd8, 4'd6, 4'd6, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
    };

    // Box type tag expected at bytes 4 to 7
    localparam logic [7:0] FTYP_TAG [4] = '{8'h66, 8'h74, 8'h79, 8'h70};

    // Minimum byte counts for the length-gated checks
    localparam int BMP_MIN_BYTES  = 14;
    localparam int ICO_MIN_BYTES  = 6;
    localparam int HEIF_MIN_BYTES = 12;
    localparam int HEIF_MIN_BOX   = 12;

    // Offsets of interest within the header
    localparam int ICO_SIZE_LO_POS  = 4;
    localparam int ICO_SIZE_HI_POS  = 5;
    localparam int BOX_LEN_END      = 4;
    localparam int TAG_END          = 8;
    localparam int MAJOR_BRAND_LAST = 11;
    localparam int COMPAT_FIRST_END = 19;

    localparam int BRAND_COUNT = 10;
    localparam logic [31:0] HEIF_BRANDS [BRAND_COUNT] = '{
        32'h68656963, 32'h68656978, 32'h68657663, 32'h68657678, 32'h6865696D,
        32'h68656973, 32'h6865766D, 32'h68657673, 32'h6D696631, 32'h6D736631
    };

    // True if the word is one of the known HEIF brands
    function automatic logic is_heif_brand(input logic [31:0] word);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < BRAND_COUNT; k++)
        begin
            if (HEIF_BRANDS[k] == word)
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

### rtl/image_format_sniffer.sv
// Top level of the image format sniffer: byte-wise header scan and format decision.
//
//  Channel | Handshake          | Payload                      | Direction
//  --------+--------------------+------------------------------+----------
//  in      | in_valid, in_stall | data_byte, last_byte         | into block
//  out     | out_valid,out_stall| format_code, viewer_class    | out of block
//
// One byte is taken per cycle, back to back, unless a byte is held behind a stalled
// result. A byte passes through the input register, then the flag update and
// decision into the result register, which drives out_valid and the result.
// Reset clears the scan state and both valid registers; no clearing pass.
// A stalled result holds the pipeline; the input register still takes a byte
// while empty, so one transfer is absorbed during an output stall.
module image_format_sniffer
    import ifs_pkg::*;
#(
    parameter int unsigned MAX_SCAN_BYTES = 32'd65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] format_code,
    output logic [2:0] viewer_class
);

    localparam int POS_W = $clog2(64'(MAX_SCAN_BYTES) + 64'd1);
    localparam int CMP_W = (POS_W > 32) ? POS_W : 32;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_SCAN_BYTES);

    // Input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // Scan state
    logic [POS_W-1:0] pos_reg, pos_next;
    sig_flags_t       flags_reg, flags_next;
    logic             ico_nz_reg, ico_nz_next;
    logic [31:0]      box_len_reg, box_len_next;
    logic             tag_ok_reg, tag_ok_next;
    logic [31:0]      window_reg, window_next;
    logic             brand_reg, brand_next;

    // Result register
    logic  out_valid_reg, out_valid_next;
    fmt_t  fmt_reg, fmt_next;
    cls_t  cls_reg, cls_next;

    logic advance;
    logic s1_fire;
    logic take;
    logic end_of_file;

    // Pipeline control: stage moves when the result register can take a value
    assign advance     = !(out_valid_reg && out_stall);
    assign s1_fire     = s1_valid_reg && advance;
    assign take        = s1_fire && (pos_reg < MAX_POS);
    assign end_of_file = s1_fire && s1_last_reg;
    assign in_stall    = s1_valid_reg && !advance;

    assign s1_valid_next = in_valid ? 1'b1 : (s1_valid_reg && !advance);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Scan update for the byte in the input register
    always_comb
    begin
        logic [CMP_W-1:0] pos_ext;
        logic [CMP_W-1:0] box_ext;
        pos_ext      = CMP_W'(pos_reg);
        box_ext      = CMP_W'(box_len_reg);
        pos_next     = pos_reg;
        flags_next   = flags_reg;
        ico_nz_next  = ico_nz_reg;
        box_len_next = box_len_reg;
        tag_ok_next  = tag_ok_reg;
        window_next  = window_reg;
        brand_next   = brand_reg;
        if (take)
        begin
            for (int k = 0; k < SIG_COUNT; k++)
            begin
                if (pos_reg < POS_W'(SIG_LEN[k]) &&
                    SIG_BYTES[k][pos_reg[2:0]] != s1_byte_reg)
                    flags_next[k] = 1'b0;
            end
            if ((pos_reg == POS_W'(ICO_SIZE_LO_POS) || pos_reg == POS_W'(ICO_SIZE_HI_POS)) &&
                s1_byte_reg != 8'd0)
                ico_nz_next = 1'b1;
            if (pos_reg < POS_W'(BOX_LEN_END))
                box_len_next = {box_len_reg[23:0], s1_byte_reg};
            else if (pos_reg < POS_W'(TAG_END) &&
                     FTYP_TAG[pos_reg[1:0]] != s1_byte_reg)
                tag_ok_next = 1'b0;
            window_next = {window_reg[23:0], s1_byte_reg};
            if (pos_reg == POS_W'(MAJOR_BRAND_LAST) && is_heif_brand(window_next))
                brand_next = 1'b1;
            if (pos_reg >= POS_W'(COMPAT_FIRST_END) && pos_reg[1:0] == 2'b11 &&
                pos_ext < box_ext && is_heif_brand(window_next))
                brand_next = 1'b1;
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // Decision on the state that includes the current byte
    always_comb
    begin
        logic [SIG_COUNT-1:0] hit;
        for (int k = 0; k < SIG_COUNT; k++)
            hit[k] = flags_next[k] && (pos_next >= POS_W'(SIG_LEN[k]));
        if (hit[SIG_JPEG])
            fmt_next = FMT_JPEG;
        else if (hit[SIG_PNG])
            fmt_next = FMT_PNG;
        else if (hit[SIG_GIF87] || hit[SIG_GIF89])
            fmt_next = FMT_GIF;
        else if (pos_next >= POS_W'(BMP_MIN_BYTES) && hit[SIG_BMP])
            fmt_next = FMT_BMP;
        else if (hit[SIG_TIFF_II_42] || hit[SIG_TIFF_MM_42] ||
                 hit[SIG_TIFF_II_43] || hit[SIG_TIFF_MM_43])
            fmt_next = FMT_TIFF;
        else if (pos_next >= POS_W'(ICO_MIN_BYTES) && hit[SIG_ICO] && ico_nz_next)
            fmt_next = FMT_ICO;
        else if (pos_next >= POS_W'(HEIF_MIN_BYTES) && tag_ok_next &&
                 box_len_next >= 32'(HEIF_MIN_BOX) && brand_next)
            fmt_next = FMT_HEIF;
        else
            fmt_next = FMT_UNKNOWN;

        unique case (fmt_next)
            FMT_JPEG:    cls_next = CLS_JPEG;
            FMT_PNG:     cls_next = CLS_PNG;
            FMT_HEIF:    cls_next = CLS_HEIF;
            FMT_UNKNOWN: cls_next = CLS_UNSUPPORTED;
            default:     cls_next = CLS_OTHER;
        endcase
    end

    // Scan state registers: return to reset values after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            flags_reg   <= '1;
            ico_nz_reg  <= 1'b0;
            box_len_reg <= '0;
            tag_ok_reg  <= 1'b1;
            window_reg  <= '0;
            brand_reg   <= 1'b0;
        end
        else if (end_of_file)
        begin
            pos_reg     <= '0;
            flags_reg   <= '1;
            ico_nz_reg  <= 1'b0;
            box_len_reg <= '0;
            tag_ok_reg  <= 1'b1;
            window_reg  <= '0;
            brand_reg   <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            flags_reg   <= flags_next;
            ico_nz_reg  <= ico_nz_next;
            box_len_reg <= box_len_next;
            tag_ok_reg  <= tag_ok_next;
            window_reg  <= window_next;
            brand_reg   <= brand_next;
        end
    end

    // Result register
    assign out_valid_next = end_of_file ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (end_of_file)
        begin
            fmt_reg <= fmt_next;
            cls_reg <= cls_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign format_code  = fmt_reg;
    assign viewer_class = cls_reg;

    // Position never passes the scan limit
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        64'(pos_reg) <= 64'(MAX_SCAN_BYTES))
        else $error("scan position beyond limit");

    // Last byte clears the scan and loads a result
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        end_of_file |=> (pos_reg == '0) && out_valid_reg && brand_reg == 1'b0)
        else $error("scan state not cleared after last byte");

    // Viewer class agrees with the format code
    a_class_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((fmt_reg == FMT_UNKNOWN) == (cls_reg == CLS_UNSUPPORTED)) &&
                          ((fmt_reg == FMT_HEIF) == (cls_reg == CLS_HEIF)))
        else $error("viewer class inconsistent with format code");

    // Input stalls only with a byte held behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without cause");

endmodule

### dv/format_checker.sv
// Checker for the image format sniffer: byte-level format prediction and result comparison.
`timescale 1ns / 1ps

module format_checker
    import ifs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] format_code,
    input  logic [2:0] viewer_class,
    output int         fail_count,
    output int         pending_count
);

    // Bytes beyond this count are dropped by the scan
    localparam longint unsigned SCAN_LIMIT = 65536;

    // Prefix signatures, indexed as the package flag positions
    localparam logic [7:0] MAGIC [10][8] = '{
        '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00},
        '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4D, 8'h00, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam int MAGIC_LEN [10] = '{3, 8, 6, 6, 2, 4, 4, 4, 4, 4};

    // Box type "ftyp" and the accepted HEIF brands
    localparam logic [7:0] BOX_TAG [4] = '{8'h66, 8'h74, 8'h79, 8'h70};
    localparam logic [31:0] KNOWN_BRANDS [10] = '{
        32'h68656963, 32'h68656978, 32'h68657663, 32'h68657678, 32'h6865696D,
        32'h68656973, 32'h6865766D, 32'h68657673, 32'h6D696631, 32'h6D736631
    };

    typedef struct packed {
        fmt_t fmt;
        cls_t cls;
    } verdict_t;

    verdict_t awaited_formats [$];
    verdict_t oldest;

    // Scan state of the file in progress
    longint unsigned scan_pos;
    logic [9:0]      live_sigs;
    logic            ico_size_seen;
    logic [31:0]     box_len;
    logic            tag_ok;
    logic [31:0]     last_word;
    logic            brand_seen;

    function automatic void clear_scan();
        scan_pos      = 0;
        live_sigs     = '1;
        ico_size_seen = 1'b0;
        box_len       = '0;
        tag_ok        = 1'b1;
        last_word     = '0;
        brand_seen    = 1'b0;
    endfunction

    function automatic logic brand_known(input logic [31:0] w);
        logic hit;
        hit = 1'b0;
        foreach (KNOWN_BRANDS[k])
        begin
            if (KNOWN_BRANDS[k] == w)
                hit = 1'b1;
        end
        return hit;
    endfunction

    // Fold one header byte into the scan state
    function automatic void absorb_byte(input logic [7:0] b);
        longint unsigned i;
        int k;
        i = scan_pos;
        for (k = 0; k < 10; k++)
        begin
            if (i < MAGIC_LEN[k] && MAGIC[k][i[2:0]] != b)
                live_sigs[k] = 1'b0;
        end
        if ((i == 4 || i == 5) && b != 8'h00)
            ico_size_seen = 1'b1;
        if (i < 4)
            box_len = {box_len[23:0], b};
        else if (i < 8 && BOX_TAG[i[1:0]] != b)
            tag_ok = 1'b0;
        last_word = {last_word[23:0], b};
        // major brand, then each compatible brand wholly inside the box
        if (i == 11 && brand_known(last_word))
            brand_seen = 1'b1;
        if (i >= 19 && i[1:0] == 2'b11 && i + 1 <= box_len && brand_known(last_word))
            brand_seen = 1'b1;
        scan_pos = i + 1;
    endfunction

    function automatic logic sig_done(input int k, input longint unsigned n);
        return live_sigs[k] && n >= MAGIC_LEN[k];
    endfunction

    // Pick the format in priority order and map it to a viewer class
    function automatic verdict_t decide_format();
        longint unsigned n;
        verdict_t v;
        n = scan_pos;
        if (sig_done(SIG_JPEG, n))
            v.fmt = FMT_JPEG;
        else if (sig_done(SIG_PNG, n))
            v.fmt = FMT_PNG;
        else if (sig_done(SIG_GIF87, n) || sig_done(SIG_GIF89, n))
            v.fmt = FMT_GIF;
        else if (n >= 14 && sig_done(SIG_BMP, n))
            v.fmt = FMT_BMP;
        else if (sig_done(SIG_TIFF_II_42, n) || sig_done(SIG_TIFF_MM_42, n) ||
                 sig_done(SIG_TIFF_II_43, n) || sig_done(SIG_TIFF_MM_43, n))
            v.fmt = FMT_TIFF;
        else if (n >= 6 && sig_done(SIG_ICO, n) && ico_size_seen)
            v.fmt = FMT_ICO;
        else if (n >= 12 && tag_ok && box_len >= 12 && brand_seen)
            v.fmt = FMT_HEIF;
        else
            v.fmt = FMT_UNKNOWN;
        case (v.fmt)
            FMT_JPEG:    v.cls = CLS_JPEG;
            FMT_PNG:     v.cls = CLS_PNG;
            FMT_HEIF:    v.cls = CLS_HEIF;
            FMT_UNKNOWN: v.cls = CLS_UNSUPPORTED;
            default:     v.cls = CLS_OTHER;
        endcase
        return v;
    endfunction

    function automatic void log_fault(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Compare each result transfer, then predict from each byte transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            awaited_formats.delete();
            fail_count = 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_formats.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with none expected: format_code %0d",
                                 $time, format_code);
                end
                else
                begin
                    oldest = awaited_formats.pop_front();
                    if (format_code !== oldest.fmt)
                        log_fault("format_code", oldest.fmt, format_code);
                    if (viewer_class !== oldest.cls)
                        log_fault("viewer_class", oldest.cls, viewer_class);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (scan_pos < SCAN_LIMIT)
                    absorb_byte(data_byte);
                if (last_byte)
                begin
                    awaited_formats.push_back(decide_format());
                    clear_scan();
                end
            end
            pending_count <= awaited_formats.size();
        end
    end

endmodule

### dv/tb_image_format_sniffer.sv
// Testbench top for the image format sniffer: header stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_image_format_sniffer;
    import ifs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BYTES    = 150;

    typedef enum int {
        HDR_NOISE,
        HDR_SIG,
        HDR_HEIF
    } hdr_kind_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] format_code;
    logic [2:0] viewer_class;

    int fail_count;
    int pending_count;
    int send_gap_pct;
    int stall_pct;
    int hold_len;
    int quiet_cycles;

    logic [7:0] hdr_q [$];

    image_format_sniffer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .format_code  (format_code),
        .viewer_class (viewer_class)
    );

    format_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .format_code   (format_code),
        .viewer_class  (viewer_class),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stall, or a forced hold-off while hold_len runs down
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                out_stall <= 1'b1;
                hold_len--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Abort when no transfer happens on either channel for too long
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_image_format_sniffer: errors");
                $finish;
            end
        end
    end

    // Offer one byte, idling at random first, and hold it until transferred
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_header();
        foreach (hdr_q[i])
            send_byte(hdr_q[i], i == hdr_q.size() - 1);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] brand_word();
        logic [31:0] w;
        w = HEIF_BRANDS[$urandom_range(BRAND_COUNT - 1)];
        case ($urandom_range(3))
            0:       return 32'($urandom);
            1:       return w ^ (32'h1 << $urandom_range(31));
            default: return w;
        endcase
    endfunction

    function automatic void push_word(input logic [31:0] w);
        hdr_q.push_back(w[31:24]);
        hdr_q.push_back(w[23:16]);
        hdr_q.push_back(w[15:8]);
        hdr_q.push_back(w[7:0]);
    endfunction

    // Build one random header: noise, a signature or an ftyp box, often cut short or corrupted
    task automatic build_header();
        hdr_kind_t kind;
        int len;
        int sig;
        int n_compat;
        int full;
        logic [31:0] box;
        hdr_q.delete();
        case ($urandom_range(5))
            0:       kind = HDR_NOISE;
            1, 2, 3: kind = HDR_SIG;
            default: kind = HDR_HEIF;
        endcase
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 24);
        case (kind)
            HDR_SIG:
            begin
                sig = $urandom_range(SIG_COUNT - 1);
                for (int i = 0; i < SIG_LEN[sig]; i++)
                    hdr_q.push_back(SIG_BYTES[sig][i]);
            end
            HDR_HEIF:
            begin
                n_compat = $urandom_range(5);
                full = 16 + 4 * n_compat;
                case ($urandom_range(5))
                    0:       box = full;
                    1:       box = full - $urandom_range(1, 3);
                    2:       box = $urandom_range(10, 13);
                    3:       box = 32'hFFFF_FFFF;
                    4:       box = $urandom_range(0, 64);
                    default: box = full + $urandom_range(0, 8);
                endcase
                push_word(box);
                if ($urandom_range(7) == 0)
                    push_word(32'($urandom));
                else
                    push_word(32'h66747970);
                push_word(brand_word());
                push_word(32'($urandom));
                for (int i = 0; i < n_compat; i++)
                    push_word(brand_word());
                if ($urandom_range(3) != 0)
                    len = hdr_q.size();
                else
                    len = $urandom_range(1, hdr_q.size() + 4);
            end
            default:
            begin
            end
        endcase
        // corrupt one byte of the prefix now and then
        if (hdr_q.size() > 0 && $urandom_range(7) == 0)
            hdr_q[$urandom_range(hdr_q.size() - 1)] ^= 8'($urandom_range(1, 255));
        while (hdr_q.size() < len)
            hdr_q.push_back(noise_byte());
        while (hdr_q.size() > len)
            void'(hdr_q.pop_back());
    endtask

    task automatic run_random(input int gap_pct, input int stall_chance);
        int sent;
        send_gap_pct = gap_pct;
        stall_pct    = stall_chance;
        sent = 0;
        while (sent < PHASE_BYTES)
        begin
            build_header();
            send_header();
            sent += hdr_q.size();
        end
        drain_results();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        last_byte    = 1'b0;
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_len     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short signature, JPEG, short BMP, ICO, minimal HEIF
        hdr_q = '{8'hFF};
        send_header();
        hdr_q = '{8'hFF, 8'hD8, 8'hFF};
        send_header();
        hdr_q = '{8'h42, 8'h4D};
        send_header();
        hdr_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
        send_header();
        hdr_q = '{8'h00, 8'h00, 8'h00, 8'h0C, 8'h66, 8'h74, 8'h79, 8'h70,
                  8'h6D, 8'h69, 8'h66, 8'h31};
        send_header();
        drain_results();

        // Long receiver hold-off while the sender keeps offering
        hold_len = 300;
        run_random(0, 0);
        run_random(82, 0);
        run_random(0, 82);
        run_random(7, 7);
        run_random(0, 0);

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_image_format_sniffer: clean");
        else
            $display("tb_image_format_sniffer: errors");
        $finish;
    end

endmodule
